@@ sv/tdf_pkg.sv @@
`default_nettype none

package tdf_pkg;

	localparam int unsigned FIRST_DIVISOR = 2;

	typedef struct packed {
		logic busy;
		logic done;
	} tdf_div_sts_t;

endpackage

`default_nettype wire

@@ sv/tdf_div.sv @@
`default_nettype none

module tdf_div
	import tdf_pkg::*;
#(
	parameter int unsigned WIDTH = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output tdf_div_sts_t          sts,
	output logic      [WIDTH-1:0] quotient,
	output logic      [WIDTH-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] part_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   shifted;
	logic             ge;

	assign shifted = {part_q, quo_q[WIDTH-1]};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			part_q <= ge ? WIDTH'(shifted - {1'b0, dvs_q}) : shifted[WIDTH-1:0];
			quo_q  <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = part_q;

endmodule

`default_nettype wire

@@ sv/trial_division_factorizer_core.sv @@
`default_nettype none

// Prime factorizer by trial division. Each accepted value is split into its
// prime factors, sent out one item each in ascending order with repeats;
// the final item of a run has last set. Values 0 and 1 give one item with
// factor 0 and no_factor set. Every trial divisor goes through one shared
// restoring divider that yields one quotient bit per cycle; trials run from
// 2 up to the square root of the remaining value. A large prime at the
// default width needs about 46341 trials. A new value is taken only once the
// previous run has handed its last item to the output register.
module trial_division_factorizer_core
	import tdf_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 31
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [VALUE_WIDTH-1:0] value,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [VALUE_WIDTH-1:0] factor,
	output logic                        no_factor,
	output logic                        last
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_TINY   = 2'd3;

	localparam logic [VALUE_WIDTH-1:0] FIRST_DIV = VALUE_WIDTH'(FIRST_DIVISOR);

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [VALUE_WIDTH-1:0] factor_q;
	logic                   no_factor_q;
	logic                   last_q;
	logic                   out_valid_q;

	tdf_div_sts_t           div_sts;
	logic [VALUE_WIDTH-1:0] quo;
	logic [VALUE_WIDTH-1:0] rmd;
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_divisor;

	logic                   out_free;
	logic                   stop;
	logic                   found;
	logic                   in_acc;
	logic                   load;
	logic [VALUE_WIDTH-1:0] load_factor;
	logic                   load_none;
	logic                   load_last;

	assign out_free = !out_valid_q || out_ready;
	assign stop     = div_q > quo;
	assign found    = rmd == '0;
	assign in_ready = state_q == ST_IDLE;
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = rem_q;
		div_divisor  = div_q + 1'b1;
		load         = 1'b0;
		load_factor  = rem_q;
		load_none    = 1'b0;
		load_last    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				div_dividend = value;
				div_divisor  = FIRST_DIV;
				div_start    = in_valid && (value >= FIRST_DIV);
			end
			ST_DECIDE: begin
				if (stop) begin
					load      = out_free;
					load_last = 1'b1;
				end else if (found) begin
					div_dividend = quo;
					div_divisor  = div_q;
					div_start    = out_free;
					load         = out_free;
					load_factor  = div_q;
				end else begin
					div_start = 1'b1;
				end
			end
			ST_TINY: begin
				load        = out_free;
				load_factor = '0;
				load_none   = 1'b1;
				load_last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tdf_div #(
		.WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.sts      (div_sts),
		.quotient (quo),
		.remainder(rmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (value >= FIRST_DIV) ? ST_DIV : ST_TINY;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (stop) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_TINY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rem_q <= value;
			div_q <= FIRST_DIV;
		end else if (state_q == ST_DECIDE && !stop && div_start) begin
			if (found) begin
				rem_q <= quo;
			end else begin
				div_q <= div_q + 1'b1;
			end
		end
		if (load) begin
			factor_q    <= load_factor;
			no_factor_q <= load_none;
			last_q      <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign no_factor = no_factor_q;
	assign last      = last_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider result outside wait state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("accepted item did not start a run");

	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE |-> div_q >= FIRST_DIV)
		else $error("trial divisor below first divisor");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_sts.busy)
		else $error("divider busy while idle");

endmodule

`default_nettype wire
